>>> sv/anlp_pkg.sv
package anlp_pkg;

   localparam int MaxFieldCharsDefault = 29;

   localparam int CharWidth  = 8;
   localparam int ValueWidth = 32;
   localparam int IndexWidth = 16;
   localparam int CountWidth = 16;

   // Register indexes on the csr port
   localparam logic CSR_HEX_MODE    = 1'b0;
   localparam logic CSR_VALUE_COUNT = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_COUNT = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHAR   = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG   = 2'd3;

   // Characters
   localparam logic [CharWidth-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CharWidth-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CharWidth-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CharWidth-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CharWidth-1:0] CHAR_0     = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_9     = 8'h39;
   localparam logic [CharWidth-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_UC_F  = 8'h46;
   localparam logic [CharWidth-1:0] CASE_BIT   = 8'h20;

   typedef struct packed {
      logic [CharWidth-1:0] char_in;
      logic                 first_char;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value_out;
      logic [IndexWidth-1:0]        value_index;
      logic [1:0]                   status;
      logic                         last;
   } rsp_type;

endpackage

>>> sv/ascii_number_list_parser.sv
// A result is registered, presented in the cycle after its causing character is accepted.
// Throughput: one char per cycle while req_ready; parse state updates in the accept cycle.
// The single output register frees up in the cycle its result is taken, so req_ready
// only drops while a result waits and rsp_ready is low.
// Reset (synchronous, active high): parser idle until a character with first_char,
// hex_mode 0, value_count 1, no result pending.
module ascii_number_list_parser
   import anlp_pkg::*;
#(
   parameter int MAX_FIELD_CHARS = MaxFieldCharsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CountWidth-1:0] csr_wdata
);

   localparam int LenWidth = $clog2(MAX_FIELD_CHARS + 1);

   logic                  hex_mode_ff;
   logic [CountWidth-1:0] value_count_ff;

   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [LenWidth-1:0]   len_ff, len_in;
   logic [IndexWidth-1:0] done_ff, done_in;
   logic                  fin_ff, fin_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  res_valid;
   rsp_type               res;
   logic [CharWidth-1:0]  ch;
   logic [CharWidth-1:0]  ch_upper;
   logic                  is_delim;
   logic                  is_sign;
   logic                  is_dec;
   logic                  is_hex;
   logic [3:0]            digit;
   logic [ValueWidth-1:0] acc_scaled;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Character classes
   assign ch       = req_data.char_in;
   assign ch_upper = ch & ~CASE_BIT;
   assign is_delim = ch inside {CHAR_NUL, CHAR_CR, CHAR_LF, CHAR_COMMA, CHAR_SPACE};
   assign is_sign  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
   assign is_dec   = ch inside {[CHAR_0:CHAR_9]};
   assign is_hex   = hex_mode_ff && (ch_upper inside {[CHAR_UC_A:CHAR_UC_F]});

   always_comb begin
      if (is_dec) begin
         digit = 4'(ch - CHAR_0);
      end else begin
         digit = 4'(ch_upper - CHAR_UC_A + 8'd10);
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      len_in    = len_ff;
      done_in   = done_ff;
      fin_in    = fin_ff;
      res_valid = 1'b0;
      res       = '0;
      acc_scaled = '0;
      if (req_fire) begin
         if (req_data.first_char) begin
            acc_in  = '0;
            neg_in  = 1'b0;
            len_in  = '0;
            done_in = '0;
            fin_in  = 1'b0;
            if (value_count_ff == '0) begin
               fin_in     = 1'b1;
               res_valid  = 1'b1;
               res.status = STATUS_ZERO_COUNT;
               res.last   = 1'b1;
            end
         end
         if (!fin_in) begin
            if (is_delim) begin
               res_valid       = 1'b1;
               res.value_out   = neg_in ? -acc_in : acc_in;
               res.value_index = done_in;
               res.status      = STATUS_OK;
               res.last        = ({1'b0, done_in} + 17'd1) >= {1'b0, value_count_ff};
               done_in         = done_in + IndexWidth'(1);
               acc_in          = '0;
               neg_in          = 1'b0;
               len_in          = '0;
               fin_in          = res.last;
            end else if ((!is_sign && !is_dec && !is_hex) || (is_sign && len_in != '0)) begin
               res_valid       = 1'b1;
               res.value_index = done_in;
               res.status      = STATUS_BAD_CHAR;
               res.last        = 1'b1;
               fin_in          = 1'b1;
            end else if (len_in >= LenWidth'(MAX_FIELD_CHARS)) begin
               res_valid       = 1'b1;
               res.value_index = done_in;
               res.status      = STATUS_TOO_LONG;
               res.last        = 1'b1;
               fin_in          = 1'b1;
            end else begin
               if (is_sign) begin
                  neg_in = (ch == CHAR_MINUS);
               end else begin
                  // x16 is a shift, x10 is x8 + x2
                  if (hex_mode_ff) begin
                     acc_scaled = acc_in << 4;
                  end else begin
                     acc_scaled = (acc_in << 3) + (acc_in << 1);
                  end
                  acc_in = acc_scaled + ValueWidth'(digit);
               end
               len_in = len_in + LenWidth'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_mode_ff    <= 1'b0;
         value_count_ff <= CountWidth'(1);
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         len_ff         <= '0;
         done_ff        <= '0;
         fin_ff         <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HEX_MODE:    hex_mode_ff    <= csr_wdata[0];
               CSR_VALUE_COUNT: value_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         len_ff       <= len_in;
         done_ff      <= done_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/anlp_checker.sv
module anlp_checker
   import anlp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A pending result stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   // Input side is only held off by a stalled result
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled result");

   // Any error ends the buffer with a zero value
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.last && rsp_data.value_out == '0)
      else $error("error result not final or value not zero");

   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ZERO_COUNT |-> rsp_data.value_index == '0)
      else $error("zero count result with nonzero index");

   // A new result after a transfer with no character taken is impossible
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result appeared without an input transfer");

endmodule

bind ascii_number_list_parser anlp_checker u_anlp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
